// ===== hw/rtl/e2c_pkg.sv =====
// Shared types and constants for the epoch-seconds to calendar converter.
// No dependencies; the pipeline stages, the top level and the testbench import this package.
package e2c_pkg;

  // Reciprocals for division by a constant: floor(2^k / c), k = dividend width
  localparam logic [26:0] RECIP_SEC  = 27'd71582788;  // 2^32 / 60
  localparam logic [21:0] RECIP_MIN  = 22'd2236962;   // 2^27 / 60
  localparam logic [16:0] RECIP_HOUR = 17'd87381;     // 2^21 / 24
  localparam logic [11:0] RECIP_YEAR = 12'd2870;      // 2^22 / 1461

  localparam logic [11:0] DAYS_PER_CYCLE = 12'd1461;
  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [11:0] CENTURY_2000   = 12'd2000;
  localparam logic [11:0] CENTURY_1900   = 12'd1900;
  // 1970 * 1461 - 2, the constant term of the four-year-cycle year formula
  localparam logic [21:0] YEAR_BIAS      = 22'd2878168;

  localparam int NUM_MONTHS = 12;

  // Days of a common year that come before each month, January first
  localparam logic [8:0] MONTH_START [NUM_MONTHS] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Time of day and whole days since the epoch (0-based)
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [15:0] days;
  } e2c_tod_t;

  // Finished calendar result
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } e2c_cal_t;

endpackage

// ===== hw/rtl/e2c_epoch_if.sv =====
// Input channel of the converter: seconds since the epoch, valid/ready.
// No dependencies.
interface e2c_epoch_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== hw/rtl/e2c_cal_if.sv =====
// Output channel of the converter: calendar fields, valid/ready.
// No dependencies.
interface e2c_cal_if;
  logic       valid;
  logic       ready;
  logic [5:0] second_of_minute;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [4:0] day_of_month;
  logic [3:0] month_number;
  logic [6:0] two_digit_year;

  modport source (output valid, output second_of_minute, output minute_of_hour,
                  output hour_of_day, output day_of_month, output month_number,
                  output two_digit_year, input ready);
  modport sink   (input valid, input second_of_minute, input minute_of_hour,
                  input hour_of_day, input day_of_month, input month_number,
                  input two_digit_year, output ready);
endinterface

// ===== hw/rtl/e2c_time_split.sv =====
// Six-stage pipeline: seconds -> second, minute, hour and whole day count.
// Depends on e2c_pkg (reciprocal constants, e2c_tod_t).
module e2c_time_split (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       epoch_seconds,
  output logic              out_valid,
  output e2c_pkg::e2c_tod_t out_data
);
  import e2c_pkg::*;

  logic [5:0] valid;

  // Stage registers
  logic [31:0] s1_secs;
  logic [26:0] s1_qest;
  logic [26:0] s2_mins;
  logic [5:0]  s2_sec;
  logic [26:0] s3_mins;
  logic [20:0] s3_qest;
  logic [5:0]  s3_sec;
  logic [20:0] s4_hours;
  logic [5:0]  s4_min;
  logic [5:0]  s4_sec;
  logic [20:0] s5_hours;
  logic [15:0] s5_qest;
  logic [5:0]  s5_min;
  logic [5:0]  s5_sec;

  logic [58:0] prod_sec;
  logic [48:0] prod_min;
  logic [37:0] prod_hour;
  logic [31:0] rem_sec;
  logic [26:0] rem_min;
  logic [20:0] rem_hour;

  assign prod_sec  = 59'(epoch_seconds) * 59'(RECIP_SEC);
  assign prod_min  = 49'(s2_mins) * 49'(RECIP_MIN);
  assign prod_hour = 38'(s4_hours) * 38'(RECIP_HOUR);

  // Remainders of the low estimates, each below twice the divisor
  assign rem_sec  = s1_secs - 32'(s1_qest) * 32'd60;
  assign rem_min  = s3_mins - 27'(s3_qest) * 27'd60;
  assign rem_hour = s5_hours - 21'(s5_qest) * 21'd24;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Estimate seconds / 60
      s1_secs <= epoch_seconds;
      s1_qest <= prod_sec[58:32];

      // Correct estimate: minutes total and second field
      if (rem_sec[6:0] >= 7'd60) begin
        s2_mins <= s1_qest + 27'd1;
        s2_sec  <= 6'(rem_sec[6:0] - 7'd60);
      end else begin
        s2_mins <= s1_qest;
        s2_sec  <= rem_sec[5:0];
      end

      // Estimate minutes / 60
      s3_mins <= s2_mins;
      s3_qest <= prod_min[47:27];
      s3_sec  <= s2_sec;

      // Correct estimate: hours total and minute field
      if (rem_min[6:0] >= 7'd60) begin
        s4_hours <= s3_qest + 21'd1;
        s4_min   <= 6'(rem_min[6:0] - 7'd60);
      end else begin
        s4_hours <= s3_qest;
        s4_min   <= rem_min[5:0];
      end
      s4_sec <= s3_sec;

      // Estimate hours / 24
      s5_hours <= s4_hours;
      s5_qest  <= prod_hour[36:21];
      s5_min   <= s4_min;
      s5_sec   <= s4_sec;

      // Correct estimate: day count and hour field
      if (rem_hour[5:0] >= 6'd24) begin
        out_data.days <= s5_qest + 16'd1;
        out_data.hour <= 5'(rem_hour[5:0] - 6'd24);
      end else begin
        out_data.days <= s5_qest;
        out_data.hour <= rem_hour[4:0];
      end
      out_data.minute <= s5_min;
      out_data.second <= s5_sec;
    end
  end

  assign out_valid = valid[5];

endmodule

// ===== hw/rtl/e2c_date_split.sv =====
// Six-stage pipeline: day count -> two-digit year, month and day of month.
// Depends on e2c_pkg (year constants, month table, e2c_tod_t, e2c_cal_t).
module e2c_date_split (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  e2c_pkg::e2c_tod_t in_data,
  output logic              out_valid,
  output e2c_pkg::e2c_cal_t out_data
);
  import e2c_pkg::*;

  logic [5:0] valid;

  e2c_tod_t    d1_tod, d2_tod, d3_tod, d4_tod, d5_tod;
  logic [21:0] d1_num, d2_num;
  logic [15:0] d1_day1, d2_day1, d3_day1;
  logic [11:0] d2_yest;
  logic [11:0] d3_year;
  logic [8:0]  d4_doy, d5_doy;
  logic [6:0]  d4_yy, d5_yy;
  logic        d4_leap, d5_leap;
  logic [3:0]  d5_midx;

  logic [33:0] prod_year;
  logic [21:0] rem_year;
  logic [7:0]  elapsed;
  logic [8:0]  elapsed_inc;
  logic [16:0] doy_full;
  logic [NUM_MONTHS-2:0] past_end;
  logic [8:0]  month_base;

  assign prod_year = 34'(d1_num) * 34'(RECIP_YEAR);
  assign rem_year  = d2_num - 22'(d2_yest) * 22'(DAYS_PER_CYCLE);

  // Day of year from the days of earlier years
  assign elapsed     = 8'(d3_year - EPOCH_YEAR);
  assign elapsed_inc = 9'(elapsed) + 9'd1;
  assign doy_full    = 17'(d3_day1) - 17'(elapsed) * 17'd365 - 17'(elapsed_inc >> 2);

  // Compare day of year against the end of each month but December
  always_comb begin
    for (int i = 1; i < NUM_MONTHS; i++) begin
      past_end[i-1] = d4_doy > (MONTH_START[i] + ((d4_leap && i >= 2) ? 9'd1 : 9'd0));
    end
  end

  assign month_base = MONTH_START[d5_midx] +
                      ((d5_leap && d5_midx >= 4'd2) ? 9'd1 : 9'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Form the four-year-cycle numerator on the 1-based day count
      d1_tod  <= in_data;
      d1_day1 <= in_data.days + 16'd1;
      d1_num  <= 22'({in_data.days, 2'b00}) + 22'd4 + YEAR_BIAS;

      // Estimate numerator / 1461
      d2_tod  <= d1_tod;
      d2_day1 <= d1_day1;
      d2_num  <= d1_num;
      d2_yest <= prod_year[33:22];

      // Correct the year estimate
      d3_tod  <= d2_tod;
      d3_day1 <= d2_day1;
      d3_year <= (rem_year >= 22'(DAYS_PER_CYCLE)) ? d2_yest + 12'd1 : d2_yest;

      // Drop earlier years; fold the year to two digits
      d4_tod  <= d3_tod;
      d4_doy  <= doy_full[8:0];
      if (d3_year >= CENTURY_2000) begin
        d4_yy   <= 7'(d3_year - CENTURY_2000);
        d4_leap <= (d3_year[1:0] == 2'b00);
      end else begin
        d4_yy   <= 7'(d3_year - CENTURY_1900);
        d4_leap <= (d3_year[1:0] == 2'b00);
      end

      // Month index is the number of month ends passed
      d5_tod  <= d4_tod;
      d5_doy  <= d4_doy;
      d5_yy   <= d4_yy;
      d5_leap <= d4_leap;
      d5_midx <= 4'($countones(past_end));

      // Remove the days before the month
      out_data.second <= d5_tod.second;
      out_data.minute <= d5_tod.minute;
      out_data.hour   <= d5_tod.hour;
      out_data.day    <= 5'(d5_doy - month_base);
      out_data.month  <= d5_midx + 4'd1;
      out_data.year   <= d5_yy;
    end
  end

  assign out_valid = valid[5];

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Converts seconds since 1970-01-01 00:00:00 to a calendar date and time.
// Uses the channel interfaces and the time and date pipeline stages.
//
// Channels: epoch (sink) carries epoch_seconds; calendar (source) carries
// second_of_minute, minute_of_hour, hour_of_day, day_of_month, month_number
// and two_digit_year. Each moves one item per transfer, valid and ready high.
// Years follow the Julian four-year leap rule, exact for 1970 to 2099.
//
// Six stages split off seconds, minutes and hours with reciprocal multipliers,
// six more find the year, the day of year and the month. One item enters per
// cycle while the output is not stalled, so the block then sustains one result
// per cycle; the multiply of each divide and its correction sit in separate
// stages.
//
// Reset (synchronous, active high) clears the stage valid bits; the data
// registers are not reset. When the receiver stalls a valid result, every
// stage holds and epoch.ready drops, so nothing is lost or repeated.
module epoch_seconds_to_calendar (
  input  logic               clk,
  input  logic               rst,
  e2c_epoch_if.sink          epoch,
  e2c_cal_if.source          calendar
);
  import e2c_pkg::*;

  logic     en;
  logic     tod_valid;
  e2c_tod_t tod;
  logic     cal_valid;
  e2c_cal_t cal;

  // Advance the whole pipeline unless a result waits at the output
  assign en          = !cal_valid || calendar.ready;
  assign epoch.ready = en;

  e2c_time_split u_time (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (epoch.valid),
    .epoch_seconds (epoch.epoch_seconds),
    .out_valid     (tod_valid),
    .out_data      (tod)
  );

  e2c_date_split u_date (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (tod_valid),
    .in_data   (tod),
    .out_valid (cal_valid),
    .out_data  (cal)
  );

  assign calendar.valid            = cal_valid;
  assign calendar.second_of_minute = cal.second;
  assign calendar.minute_of_hour   = cal.minute;
  assign calendar.hour_of_day      = cal.hour;
  assign calendar.day_of_month     = cal.day;
  assign calendar.month_number     = cal.month;
  assign calendar.two_digit_year   = cal.year;

  // Time fields out of range point to a bad divide correction
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> cal.second < 6'd60 && cal.minute < 6'd60 && cal.hour < 5'd24)
    else $error("time field out of range");

  // Date fields out of range point to a bad year or month step
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> cal.day >= 5'd1 && cal.day <= 5'd31 &&
                  cal.month >= 4'd1 && cal.month <= 4'd12)
    else $error("date field out of range");

  // February never runs past its length for the year
  a_feb_len: assert property (@(posedge clk) disable iff (rst)
    cal_valid && cal.month == 4'd2 |-> cal.day <= 5'd28 ||
                                       (cal.day == 5'd29 && cal.year[1:0] == 2'b00))
    else $error("February day beyond month length");

  // Thirty-day months never show day 31
  a_short_month: assert property (@(posedge clk) disable iff (rst)
    cal_valid && (cal.month == 4'd4 || cal.month == 4'd6 ||
                  cal.month == 4'd9 || cal.month == 4'd11) |-> cal.day <= 5'd30)
    else $error("day 31 in a thirty-day month");

endmodule

// ===== bench/tb_epoch_seconds_to_calendar.sv =====
// Self-checking testbench for the epoch-seconds to calendar converter.
// Depends on e2c_pkg, the two channel interfaces and the converter top level.
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar;
  import e2c_pkg::*;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned JULIAN_CYCLE = 1461;
  localparam int unsigned BASE_YEAR    = 1970;
  localparam int unsigned DRAIN_CYCLES = 30;

  // Days of each month in a common year, January at index 1
  localparam int unsigned MONTH_LEN [1:12] = '{31, 28, 31, 30, 31, 30,
                                              31, 31, 30, 31, 30, 31};

  logic clk;
  logic rst;

  e2c_epoch_if epoch_ch ();
  e2c_cal_if   cal_ch ();

  epoch_seconds_to_calendar i_dut (
    .clk      (clk),
    .rst      (rst),
    .epoch    (epoch_ch),
    .calendar (cal_ch)
  );

  e2c_cal_t    pending_dates [$];
  int unsigned dates_sent;
  int unsigned dates_checked;
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_cyc;

  // Predict the calendar fields for one epoch value
  function automatic e2c_cal_t civil_from_epoch(input logic [31:0] secs);
    e2c_cal_t    cal;
    int unsigned day_num;
    int unsigned full_year;
    int unsigned yy;
    int unsigned elapsed;
    int unsigned mon;
    int unsigned mlen;
    bit          done;
    cal.second = 6'(secs % 32'd60);
    cal.minute = 6'((secs / 32'd60) % 32'd60);
    cal.hour   = 5'((secs / 32'd3600) % 32'd24);
    // 1-based day number, then the Julian four-year-cycle year
    day_num   = secs / SECS_PER_DAY + 32'd1;
    full_year = (day_num * 32'd4 + BASE_YEAR * JULIAN_CYCLE - 32'd2) / JULIAN_CYCLE;
    yy        = (full_year >= 32'd2000) ? full_year - 32'd2000 : full_year - 32'd1900;
    elapsed   = full_year - BASE_YEAR;
    day_num   = day_num - (32'd365 * elapsed + (elapsed + 32'd1) / 32'd4);
    // Strip whole months
    mon  = 1;
    done = 1'b0;
    while (!done) begin
      if (mon > 12) begin
        done = 1'b1;
      end else begin
        mlen = MONTH_LEN[mon];
        if (mon == 2 && (yy % 4) == 0) mlen = 29;
        if (day_num > mlen) begin
          day_num = day_num - mlen;
          mon++;
        end else begin
          done = 1'b1;
        end
      end
    end
    cal.day   = 5'(day_num);
    cal.month = 4'(mon);
    cal.year  = 7'(yy);
    return cal;
  endfunction

  // Encode a Julian-rule calendar date and time as epoch seconds
  function automatic logic [31:0] epoch_of(input int y, input int m, input int d,
                                           input int hh, input int mi, input int ss);
    longint unsigned dn;
    dn = 64'(365 * (y - 1970) + (y - 1969) / 4 + int'(MONTH_START[m - 1]) + d - 1);
    if (y % 4 == 0 && m > 2) dn++;
    return 32'(dn * 64'd86400 + 64'(hh * 3600 + mi * 60 + ss));
  endfunction

  // Send one epoch value in bursts with random gaps; record its expected date
  task automatic send_epoch(input logic [31:0] secs);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        epoch_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    epoch_ch.valid         <= 1'b1;
    epoch_ch.epoch_seconds <= secs;
    @(posedge clk);
    while (!epoch_ch.ready) @(posedge clk);
    pending_dates.push_back(civil_from_epoch(secs));
    dates_sent++;
  endtask

  // Drop valid and hold until every expected date has arrived
  task automatic hold_until_drained();
    epoch_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  // Corners of the field and of the calendar
  task automatic test_directed_corners();
    send_epoch(32'd0);
    send_epoch(32'hFFFF_FFFF);
    send_epoch(32'd59);
    send_epoch(32'd60);
    send_epoch(32'd3599);
    send_epoch(32'd86399);
    send_epoch(32'd86400);
    send_epoch(32'h7FFF_FFFF);
    send_epoch(32'h8000_0000);
    send_epoch(32'hAAAA_AAAA);
    send_epoch(32'h5555_5555);
    // first leap February and a common one
    send_epoch(epoch_of(1972, 2, 28, 23, 59, 59));
    send_epoch(epoch_of(1972, 2, 29, 0, 0, 0));
    send_epoch(epoch_of(1972, 3, 1, 0, 0, 0));
    send_epoch(epoch_of(1973, 2, 28, 23, 59, 59));
    send_epoch(epoch_of(1973, 3, 1, 0, 0, 0));
    // two-digit year wraps from 99 to 0
    send_epoch(epoch_of(1999, 12, 31, 23, 59, 59));
    send_epoch(epoch_of(2000, 1, 1, 0, 0, 0));
    send_epoch(epoch_of(2000, 2, 29, 12, 34, 56));
    // past 2099 the year field runs on and 2100 stays a leap year
    send_epoch(epoch_of(2099, 12, 31, 23, 59, 59));
    send_epoch(epoch_of(2100, 2, 29, 0, 0, 0));
    send_epoch(epoch_of(2100, 3, 1, 0, 0, 0));
    send_epoch(epoch_of(2106, 1, 1, 0, 0, 0));
  endtask

  // Full-range random seconds
  task automatic test_random_full(input int unsigned count);
    repeat (count) send_epoch($urandom);
  endtask

  // Seconds near the end or start of random months
  task automatic test_month_edges(input int unsigned count);
    int y;
    int m;
    int last;
    repeat (count) begin
      y    = $urandom_range(1970, 2105);
      m    = $urandom_range(1, 12);
      last = MONTH_LEN[m];
      if (m == 2 && y % 4 == 0) last = 29;
      if ($urandom_range(0, 1) == 0)
        send_epoch(epoch_of(y, m, last, 23, 59, $urandom_range(50, 59)));
      else
        send_epoch(epoch_of(y, m, 1, 0, $urandom_range(0, 1), $urandom_range(0, 59)));
    end
  endtask

  // Late February and early March of random years, leap or not
  task automatic test_leap_days(input int unsigned count);
    int y;
    repeat (count) begin
      y = $urandom_range(1970, 2105);
      if ($urandom_range(0, 3) == 0) y = 4 * $urandom_range(493, 526);
      case ($urandom_range(0, 3))
        0: send_epoch(epoch_of(y, 2, 28, 23, 59, 59));
        1: send_epoch(epoch_of(y, 3, 1, 0, 0, 0));
        2: send_epoch(epoch_of(y, 3, 1, 23, 59, 59) - 86400);
        default: send_epoch(epoch_of(y, 2, 28, $urandom_range(0, 23),
                                     $urandom_range(0, 59), $urandom_range(0, 59)) + 86400);
      endcase
    end
  endtask

  // Short bursts, each followed by a full drain of the pipeline
  task automatic test_drain_pauses(input int unsigned rounds);
    repeat (rounds) begin
      repeat ($urandom_range(5, 20)) send_epoch($urandom);
      hold_until_drained();
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: ready pattern in one of four stall modes, picked at random
  initial begin
    cal_ch.ready = 1'b0;
    stall_mode   = 0;
    stall_cyc    = 0;
    forever begin
      @(posedge clk);
      stall_cyc++;
      if (stall_cyc % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: cal_ch.ready <= 1'b1;
        1: cal_ch.ready <= ($urandom_range(0, 3) != 0);
        2: cal_ch.ready <= ((stall_cyc % 7) < 4);
        default: cal_ch.ready <= (stall_cyc % 16 == 0);
      endcase
    end
  end

  // Compare each transferred date with the oldest expectation
  always @(posedge clk) begin : check_dates
    e2c_cal_t want;
    if (!rst && cal_ch.valid && cal_ch.ready) begin
      if (pending_dates.size() == 0) begin
        $error("date transfer with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        dates_checked++;
        if (cal_ch.second_of_minute !== want.second) begin
          $error("second_of_minute: expected %0d, got %0d", want.second,
                 cal_ch.second_of_minute);
          mismatches++;
        end
        if (cal_ch.minute_of_hour !== want.minute) begin
          $error("minute_of_hour: expected %0d, got %0d", want.minute,
                 cal_ch.minute_of_hour);
          mismatches++;
        end
        if (cal_ch.hour_of_day !== want.hour) begin
          $error("hour_of_day: expected %0d, got %0d", want.hour, cal_ch.hour_of_day);
          mismatches++;
        end
        if (cal_ch.day_of_month !== want.day) begin
          $error("day_of_month: expected %0d, got %0d", want.day, cal_ch.day_of_month);
          mismatches++;
        end
        if (cal_ch.month_number !== want.month) begin
          $error("month_number: expected %0d, got %0d", want.month, cal_ch.month_number);
          mismatches++;
        end
        if (cal_ch.two_digit_year !== want.year) begin
          $error("two_digit_year: expected %0d, got %0d", want.year,
                 cal_ch.two_digit_year);
          mismatches++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst                    = 1'b1;
    epoch_ch.valid         = 1'b0;
    epoch_ch.epoch_seconds = 32'd0;
    dates_sent             = 0;
    dates_checked          = 0;
    mismatches             = 0;
    burst_left             = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_random_full(300);
    test_month_edges(200);
    test_leap_days(100);
    test_drain_pauses(8);

    // Wait out the pipeline and watch for stray transfers
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d epoch values, %0d dates checked: corners, full-range random,",
             dates_sent, dates_checked);
    $display("month and leap-day edges up to 2106, random gaps, stalls and drain pauses.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/e2c_pkg.sv
hw/rtl/e2c_epoch_if.sv
hw/rtl/e2c_cal_if.sv
hw/rtl/e2c_time_split.sv
hw/rtl/e2c_date_split.sv
hw/rtl/epoch_seconds_to_calendar.sv
bench/tb_epoch_seconds_to_calendar.sv
